// ===== hdl/rkw_pkg.sv =====
// shared types, widths, constants and the exp table of the range kernel weight unit
`default_nettype none
package rkw_pkg;

  // field widths
  localparam int DIFF_W    = 16;
  localparam int SIGMA_W   = 16;
  localparam int WEIGHT_W  = 32;
  localparam int AX_W      = DIFF_W + 1;
  localparam int X2_W      = 2 * DIFF_W - 1;
  localparam int S2_W      = 2 * SIGMA_W;
  localparam int DEN5_W    = S2_W + 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_SCALE = 2'd1;
  localparam logic [SIGMA_W-1:0]   SIGMA_RESET     = 16'd256;

  typedef enum logic [2:0] {
    KM_GAUSS    = 3'd0,
    KM_UNSCALED = 3'd1,
    KM_HUBER    = 3'd2,
    KM_TUKEY    = 3'd3,
    KM_LORENTZ  = 3'd4
  } kmode_t;

  // exp(-u) table, u in [0,16], Q30 samples
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int TAB_W           = 31;
  localparam int FRAC_W          = 16;

  // taylor terms of exp(-16/depth) in Q58
  localparam logic [63:0] EXP_STEP = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] EXP_T0  = 64'd1 << 58;
  localparam logic [63:0] EXP_T1  = (EXP_T0  * 64'd16) / (EXP_STEP * 64'd1);
  localparam logic [63:0] EXP_T2  = (EXP_T1  * 64'd16) / (EXP_STEP * 64'd2);
  localparam logic [63:0] EXP_T3  = (EXP_T2  * 64'd16) / (EXP_STEP * 64'd3);
  localparam logic [63:0] EXP_T4  = (EXP_T3  * 64'd16) / (EXP_STEP * 64'd4);
  localparam logic [63:0] EXP_T5  = (EXP_T4  * 64'd16) / (EXP_STEP * 64'd5);
  localparam logic [63:0] EXP_T6  = (EXP_T5  * 64'd16) / (EXP_STEP * 64'd6);
  localparam logic [63:0] EXP_T7  = (EXP_T6  * 64'd16) / (EXP_STEP * 64'd7);
  localparam logic [63:0] EXP_T8  = (EXP_T7  * 64'd16) / (EXP_STEP * 64'd8);
  localparam logic [63:0] EXP_T9  = (EXP_T8  * 64'd16) / (EXP_STEP * 64'd9);
  localparam logic [63:0] EXP_T10 = (EXP_T9  * 64'd16) / (EXP_STEP * 64'd10);
  localparam logic [63:0] EXP_T11 = (EXP_T10 * 64'd16) / (EXP_STEP * 64'd11);
  localparam logic [63:0] EXP_T12 = (EXP_T11 * 64'd16) / (EXP_STEP * 64'd12);
  localparam logic [63:0] EXP_T13 = (EXP_T12 * 64'd16) / (EXP_STEP * 64'd13);
  localparam logic [63:0] EXP_T14 = (EXP_T13 * 64'd16) / (EXP_STEP * 64'd14);
  localparam logic [63:0] EXP_T15 = (EXP_T14 * 64'd16) / (EXP_STEP * 64'd15);
  localparam logic [63:0] EXP_T16 = (EXP_T15 * 64'd16) / (EXP_STEP * 64'd16);
  localparam logic [63:0] EXP_T17 = (EXP_T16 * 64'd16) / (EXP_STEP * 64'd17);
  localparam logic [63:0] EXP_T18 = (EXP_T17 * 64'd16) / (EXP_STEP * 64'd18);
  localparam logic [63:0] EXP_T19 = (EXP_T18 * 64'd16) / (EXP_STEP * 64'd19);
  localparam logic [63:0] EXP_T20 = (EXP_T19 * 64'd16) / (EXP_STEP * 64'd20);
  localparam logic [63:0] EXP_T21 = (EXP_T20 * 64'd16) / (EXP_STEP * 64'd21);
  localparam logic [63:0] EXP_T22 = (EXP_T21 * 64'd16) / (EXP_STEP * 64'd22);
  localparam logic [63:0] EXP_T23 = (EXP_T22 * 64'd16) / (EXP_STEP * 64'd23);
  localparam logic [63:0] EXP_T24 = (EXP_T23 * 64'd16) / (EXP_STEP * 64'd24);
  localparam logic [63:0] EXP_SUM =
      EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7
    + EXP_T8 - EXP_T9 + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13 + EXP_T14
    - EXP_T15 + EXP_T16 - EXP_T17 + EXP_T18 - EXP_T19 + EXP_T20 - EXP_T21
    + EXP_T22 - EXP_T23 + EXP_T24;
  // ratio of neighboring samples in Q30
  localparam logic [63:0] EXP_RATIO = (EXP_SUM + (64'd1 << 27)) >> 28;

  // sqrt(2*pi) in Q24
  localparam int C_W = 26;
  localparam logic [C_W-1:0] SQRT_2_PI_Q24 = 26'd42054244;
  localparam int SC_W = SIGMA_W + C_W;

  // shifts of the fixed point setup
  localparam int GS_SHIFT  = 11;
  localparam int TK_SHIFT  = 28;
  localparam int LZ_SHIFT  = 16;
  localparam int HUBER_LOG = 24;
  localparam int TK_OUT    = 41;
  localparam int GS_OUT    = 18;
  localparam int UG_OUT    = 14;

  // shared divider geometry
  localparam int DIV_QW = 29;
  localparam int DIV_DW = SC_W;
  localparam int DIV_NW = DIV_QW + DIV_DW;

  typedef logic [TAB_W-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

  typedef struct packed {
    kmode_t                mode;
    logic                  zero;
    logic [WEIGHT_W-1:0]   w;
  } side_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    side_t             side;
  } div_in_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_QW-1:0] quot;
    side_t             side;
  } div_out_t;

  // repeated products of the neighbor ratio
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] prod;
    tab[0] = TAB_W'(64'd1 << 30);
    for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
      prod   = 64'(tab[i-1]) * EXP_RATIO;
      tab[i] = TAB_W'((prod + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ===== hdl/rkw_if.sv =====
// stream interfaces of the input differences and the weight results
`default_nettype none
interface rkw_in_if;
  import rkw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] diff_value;
  modport source (output valid, output diff_value, input ready);
  modport sink (input valid, input diff_value, output ready);
endinterface

interface rkw_out_if;
  import rkw_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                saturated;
  modport source (output valid, output weight, output saturated, input ready);
  modport sink (input valid, input weight, input saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/rkw_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module rkw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rkw_pkg::div_in_t  din,
  output rkw_pkg::div_out_t dout
);
  import rkw_pkg::*;

  logic [DIV_QW-1:0] vld_r;
  logic [DIV_QW-1:0] vld_nxt;
  logic [DIV_DW-1:0] rem_r   [DIV_QW];
  logic [DIV_DW-1:0] rem_nxt [DIV_QW];
  logic [DIV_QW-1:0] lq_r    [DIV_QW];
  logic [DIV_QW-1:0] lq_nxt  [DIV_QW];
  logic [DIV_DW-1:0] den_r   [DIV_QW];
  side_t             side_r  [DIV_QW];

  // one compare and subtract per stage
  always_comb begin
    logic [DIV_DW-1:0] p_rem;
    logic [DIV_QW-1:0] p_lq;
    logic [DIV_DW-1:0] p_den;
    logic [DIV_DW:0]   t;
    for (int k = 0; k < DIV_QW; k++) begin
      if (k == 0) begin
        p_rem      = din.num[DIV_NW-1:DIV_QW];
        p_lq       = din.num[DIV_QW-1:0];
        p_den      = din.den;
        vld_nxt[k] = din.vld;
      end else begin
        p_rem      = rem_r[k-1];
        p_lq       = lq_r[k-1];
        p_den      = den_r[k-1];
        vld_nxt[k] = vld_r[k-1];
      end
      t = {p_rem, p_lq[DIV_QW-1]};
      if (t >= {1'b0, p_den}) begin
        rem_nxt[k] = DIV_DW'(t - {1'b0, p_den});
        lq_nxt[k]  = {p_lq[DIV_QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[DIV_DW-1:0];
        lq_nxt[k]  = {p_lq[DIV_QW-2:0], 1'b0};
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        lq_r[k]  <= lq_nxt[k];
        if (k == 0) begin
          den_r[k]  <= din.den;
          side_r[k] <= din.side;
        end else begin
          den_r[k]  <= den_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign dout.vld  = vld_r[DIV_QW-1];
  assign dout.quot = lq_r[DIV_QW-1];
  assign dout.side = side_r[DIV_QW-1];

endmodule
`default_nettype wire

// ===== hdl/rkw_prep.sv =====
// front stages: magnitude, squares and per-kernel dividend and divisor
`default_nettype none
module rkw_prep (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [rkw_pkg::DIFF_W-1:0]  in_diff,
  input  rkw_pkg::kmode_t                    mode,
  input  logic [rkw_pkg::SIGMA_W-1:0]        sigma,
  output rkw_pkg::div_in_t                   dout
);
  import rkw_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic [AX_W-1:0]     ax1_r;
  logic [X2_W-1:0]     x2_r;
  logic [S2_W-1:0]     s2_r;
  logic [AX_W-1:0]     dh2_r;
  logic [2*AX_W-1:0]   axsq;
  logic [AX_W-1:0]     ax;
  logic [DEN5_W-1:0]   den5;
  logic [S2_W:0]       lor_den;
  logic [DIV_NW-1:0]   num_nxt;
  logic [DIV_DW-1:0]   den_nxt;
  logic                zero_nxt;
  logic [DIV_NW-1:0]   num3_r;
  logic [DIV_DW-1:0]   den3_r;
  logic                zero3_r;
  kmode_t              mode3_r;

  // absolute value, the most negative input is exact in 17 bits
  assign ax = in_diff[DIFF_W-1] ? AX_W'(18'h10000 - {2'b00, in_diff})
                                : {1'b0, in_diff};
  assign axsq = ax1_r * ax1_r;

  // kernel setup for the first division
  assign den5    = (DEN5_W'(s2_r) << 2) + DEN5_W'(s2_r);
  assign lor_den = (S2_W+1)'(s2_r) + (S2_W+1)'(x2_r);

  always_comb begin
    num_nxt  = '0;
    den_nxt  = DIV_DW'(s2_r);
    zero_nxt = 1'b0;
    case (mode)
      KM_HUBER: begin
        num_nxt = (DIV_NW'(1) << HUBER_LOG) + DIV_NW'(dh2_r >> 1);
        den_nxt = DIV_DW'(dh2_r);
      end
      KM_TUKEY: begin
        zero_nxt = DEN5_W'(x2_r) > den5;
        num_nxt  = zero_nxt ? '0 : DIV_NW'(den5 - DEN5_W'(x2_r)) << TK_SHIFT;
        den_nxt  = DIV_DW'(den5);
      end
      KM_LORENTZ: begin
        num_nxt = (DIV_NW'(s2_r) << LZ_SHIFT) + DIV_NW'(lor_den >> 1);
        den_nxt = DIV_DW'(lor_den);
      end
      default: begin
        zero_nxt = (S2_W+5)'(x2_r) >= ((S2_W+5)'(s2_r) << 5);
        num_nxt  = zero_nxt ? '0
                 : (DIV_NW'(x2_r) * DIV_NW'(EXP_TABLE_DEPTH)) << GS_SHIFT;
        den_nxt  = DIV_DW'(s2_r);
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r   <= ax;
      x2_r    <= X2_W'(axsq);
      s2_r    <= S2_W'(sigma) * S2_W'(sigma);
      dh2_r   <= (ax1_r > AX_W'(sigma)) ? ax1_r : AX_W'(sigma);
      num3_r  <= num_nxt;
      den3_r  <= den_nxt;
      zero3_r <= zero_nxt;
      mode3_r <= mode;
    end
  end

  assign dout.vld       = v3_r;
  assign dout.num       = num3_r;
  assign dout.den       = den3_r;
  assign dout.side.mode = mode3_r;
  assign dout.side.zero = zero3_r;
  assign dout.side.w    = '0;

endmodule
`default_nettype wire

// ===== hdl/rkw_interp.sv =====
// middle stages: exp table interpolation, tukey square, setup of the gaussian scaling
`default_nettype none
module rkw_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  rkw_pkg::div_out_t           ain,
  input  logic [rkw_pkg::SIGMA_W-1:0] sigma,
  output rkw_pkg::div_in_t            bout
);
  import rkw_pkg::*;

  logic                       v4_r, v5_r, v6_r, v7_r;
  side_t                      side4_r, side5_r, side6_r, side7_r;
  side_t                      side7_nxt;
  logic [DIV_QW-FRAC_W-1:0]   qidx;
  logic [EXP_IDX_W-1:0]       idx;
  logic [EXP_IDX_W-1:0]       idx_n;
  logic [TAB_W-1:0]           ta, tb;
  logic [TAB_W-1:0]           ta4_r, td4_r, ta5_r, e6_r;
  logic [FRAC_W-1:0]          frac4_r;
  logic [2*DIV_QW-1:0]        sq4_r;
  logic [WEIGHT_W-1:0]        wq4_r, w5_r, w6_r;
  logic [TAB_W+FRAC_W-1:0]    ip5_r;
  logic [TAB_W+FRAC_W:0]      ip_rnd;
  logic [TAB_W-1:0]           e_nxt;
  logic [WEIGHT_W-1:0]        ug_w;
  logic [SC_W-1:0]            sc_r;
  logic [DIV_NW-1:0]          num7_r;
  logic [DIV_DW-1:0]          den7_r;

  // table address, only meaningful for the gaussian kernels
  assign qidx  = ain.quot[DIV_QW-1:FRAC_W];
  assign idx   = (DIV_QW-FRAC_W)'(qidx) < (DIV_QW-FRAC_W)'(EXP_TABLE_DEPTH)
               ? EXP_IDX_W'(qidx) : '0;
  assign idx_n = EXP_IDX_W'(idx + 1'b1);
  assign ta    = EXP_TAB[idx];
  assign tb    = EXP_TAB[idx_n];

  // interpolated exp, then its rounded unscaled weight
  assign ip_rnd = {1'b0, ip5_r} + (TAB_W+FRAC_W+1)'(1 << (FRAC_W - 1));
  assign e_nxt  = ta5_r - TAB_W'(ip_rnd >> FRAC_W);
  assign ug_w   = WEIGHT_W'(({1'b0, e6_r} + 32'(1 << (UG_OUT - 1))) >> UG_OUT);

  // weight that leaves with the sideband
  always_comb begin
    side7_nxt   = side6_r;
    side7_nxt.w = (side6_r.mode == KM_UNSCALED) ? ug_w : w6_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= ain.vld;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // sigma times sqrt(2 pi); the user must keep config static while items are in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    sc_r <= SC_W'(sigma) * SC_W'(SQRT_2_PI_Q24);
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= ain.side;
      ta4_r   <= ta;
      td4_r   <= ta - tb;
      frac4_r <= ain.quot[FRAC_W-1:0];
      sq4_r   <= (2*DIV_QW)'(ain.quot) * (2*DIV_QW)'(ain.quot);
      wq4_r   <= WEIGHT_W'(ain.quot);

      side5_r <= side4_r;
      ta5_r   <= ta4_r;
      ip5_r   <= (TAB_W+FRAC_W)'(td4_r) * (TAB_W+FRAC_W)'(frac4_r);
      w5_r    <= (side4_r.mode == KM_TUKEY)
               ? WEIGHT_W'((sq4_r + ((2*DIV_QW)'(1) << (TK_OUT - 1))) >> TK_OUT)
               : wq4_r;

      side6_r <= side5_r;
      e6_r    <= side5_r.zero ? '0 : e_nxt;
      w6_r    <= w5_r;

      side7_r      <= side7_nxt;
      num7_r       <= (DIV_NW'(e6_r) << GS_OUT) + DIV_NW'(sc_r >> 1);
      den7_r       <= sc_r;
    end
  end

  assign bout.vld  = v7_r;
  assign bout.num  = num7_r;
  assign bout.den  = den7_r;
  assign bout.side = side7_r;

endmodule
`default_nettype wire

// ===== hdl/range_kernel_weight_unit_core.sv =====
// top level of the range kernel weight unit: config, input skid, pipeline, output register
//
// Takes one signed Q8.8 intensity difference per beat on in_if and returns one
// unsigned Q16.16 weight and a saturation flag per beat on out_if, in order.
// The kernel (gaussian, unscaled gaussian, huber, tukey, lorentz) and sigma are
// set through the cfg_ write port: cfg_index 0 is kernel_mode, 1 is
// sigma_scale; write only while no beat is in flight.
// Throughput: one beat per cycle while the pipeline is not held. The pipeline
// is made of two 29-stage dividers (one quotient bit each), three front
// stages, four interpolation stages and the output register.
// Reset (rst_n low, synchronous) empties the pipeline and loads kernel_mode 0
// and sigma 1.0. When a result waits and out_if.ready is low, the whole
// pipeline holds; a one-beat skid register keeps in_if.ready a registered
// signal, so one more input beat is taken in a stall; nothing is lost or repeated.
`default_nettype none
module range_kernel_weight_unit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  rkw_in_if.sink                         in_if,
  rkw_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [rkw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rkw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rkw_pkg::*;

  kmode_t                   mode_r;
  logic [SIGMA_W-1:0]       sigma_r;
  logic                     skid_full_r;
  logic                     skid_full_nxt;
  logic signed [DIFF_W-1:0] skid_diff_r;
  logic                     en;
  logic                     in_beat;
  logic                     pipe_vld;
  logic signed [DIFF_W-1:0] pipe_diff;
  div_in_t                  diva_in;
  div_out_t                 diva_out;
  div_in_t                  divb_in;
  div_out_t                 divb_out;
  logic                     out_valid_r;
  logic [WEIGHT_W-1:0]      weight_r;
  logic                     sat_r;
  logic [WEIGHT_W:0]        w_full;
  logic                     sat_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= KM_GAUSS;
      sigma_r <= SIGMA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_MODE: begin
          mode_r <= (cfg_data[2:0] > KM_LORENTZ) ? KM_GAUSS : kmode_t'(cfg_data[2:0]);
        end
        CFG_SIGMA_SCALE: begin
          sigma_r <= (cfg_data == '0) ? SIGMA_W'(1) : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline moves when the output register is free or being drained
  assign en      = !out_valid_r || out_if.ready;
  assign in_beat = in_if.valid && !skid_full_r;
  assign in_if.ready = !skid_full_r;

  // skid register catches a beat taken during a stall
  assign pipe_vld  = skid_full_r || in_beat;
  assign pipe_diff = skid_full_r ? skid_diff_r : in_if.diff_value;

  always_comb begin
    skid_full_nxt = skid_full_r;
    if (en) begin
      skid_full_nxt = 1'b0;
    end else if (in_beat) begin
      skid_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_beat) begin
      skid_diff_r <= in_if.diff_value;
    end
  end

  rkw_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pipe_vld),
    .in_diff (pipe_diff),
    .mode    (mode_r),
    .sigma   (sigma_r),
    .dout    (diva_in)
  );

  rkw_div u_diva (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (diva_in),
    .dout  (diva_out)
  );

  rkw_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ain   (diva_out),
    .sigma (sigma_r),
    .bout  (divb_in)
  );

  rkw_div u_divb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (divb_in),
    .dout  (divb_out)
  );

  // final weight select and clip
  assign w_full  = (divb_out.side.mode == KM_GAUSS) ? (WEIGHT_W+1)'(divb_out.quot)
                                                    : (WEIGHT_W+1)'(divb_out.side.w);
  assign sat_nxt = w_full[WEIGHT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= divb_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_r <= sat_nxt ? '1 : w_full[WEIGHT_W-1:0];
      sat_r    <= sat_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.weight    = weight_r;
  assign out_if.saturated = sat_r;

endmodule
`default_nettype wire
